/* rtl/core/tsa_pkg.sv */
// Shared types and codes for the tagged slot allocator.
package tsa_pkg;

  localparam int ENT_W   = 10;
  localparam int LIGHT_W = 8;
  localparam int SURF_W  = 8;
  localparam int FRAME_W = 32;
  localparam int IDX_OUT_W = 8;
  localparam int STAT_W  = 3;

  localparam logic [STAT_W-1:0] ST_HIT     = 3'd0;
  localparam logic [STAT_W-1:0] ST_OLDEST  = 3'd1;
  localparam logic [STAT_W-1:0] ST_OTHER   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED = 3'd4;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [ENT_W-1:0]   entity;
    logic [LIGHT_W-1:0] light;
    logic [SURF_W-1:0]  surface;
    logic [FRAME_W-1:0] frame;
  } entry_t;

endpackage

/* rtl/core/tagged_slot_allocator_oldest_frame.sv */
// Fully associative slot table with hit lookup and oldest-frame replacement.
// Lookup: one pass over all slots, then a decision state, then the result.
// Clear: one write sweep over all slots, then the result.
// One item at a time; the single-port read pass over the slot memory sets the rate.
// After rst the table is swept to zero; no item is taken meanwhile.
module tagged_slot_allocator_oldest_frame
  import tsa_pkg::*;
#(
  parameter int SLOT_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // entity_tag[9:0], light_tag[17:10], surface_tag[25:18],
                                 // frame_number[57:26], zero pad
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // slot_index[7:0], status[10:8], zero pad
);

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int PICK_W = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  logic             report;

  logic [ENT_W-1:0]   req_ent;
  logic [LIGHT_W-1:0] req_light;
  logic [SURF_W-1:0]  req_surf;
  logic [FRAME_W-1:0] req_frame;

  logic               hit_found, old_found, oth_found;
  logic [IDX_W-1:0]   hit_idx, old_idx, oth_idx;
  logic [FRAME_W-1:0] old_val;

  logic [IDX_OUT_W-1:0] res_index;
  logic [STAT_W-1:0]    res_status;

  // slot memory, one read and one write port
  entry_t           mem [SLOT_COUNT];
  entry_t           rdata;
  logic [IDX_W-1:0] raddr, rd_idx;
  logic             issue, rd_vld;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  logic             accept;
  logic [IDX_W-1:0] pick;
  logic [STAT_W-1:0] pick_status;
  logic [PICK_W-1:0] pick_ext;
  logic             ent_match, ent_other;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign issue    = (state == S_SCAN) && (cnt != CNT_END);
  assign raddr    = cnt[IDX_W-1:0];

  assign ent_match = rdata.valid && (rdata.entity == req_ent) &&
                     (rdata.light == req_light) && (rdata.surface == req_surf);
  assign ent_other = !rdata.valid || (rdata.light != req_light);

  always_comb begin
    priority if (hit_found) begin
      pick = hit_idx;
      pick_status = ST_HIT;
    end else if (old_found) begin
      pick = old_idx;
      pick_status = ST_OLDEST;
    end else if (oth_found) begin
      pick = oth_idx;
      pick_status = ST_OTHER;
    end else begin
      pick = '0;
      pick_status = ST_NONE;
    end
  end

  assign pick_ext = PICK_W'(pick);

  always_comb begin
    we    = 1'b0;
    waddr = pick;
    wdata = '{valid: 1'b1, entity: req_ent, light: req_light,
              surface: req_surf, frame: req_frame};
    if (state == S_CLR) begin
      we    = 1'b1;
      waddr = cnt[IDX_W-1:0];
      wdata = '0;
    end else if (state == S_DEC) begin
      we = (pick_status != ST_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata  <= mem[raddr];
    rd_idx <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      cnt      <= '0;
      report   <= 1'b0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld <= issue;
      // S_DONE loads the next item itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            if (report) begin
              res_index  <= '0;
              res_status <= ST_CLEARED;
              state      <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_ent   <= s_tdata[9:0];
            req_light <= s_tdata[17:10];
            req_surf  <= s_tdata[25:18];
            req_frame <= s_tdata[57:26];
            old_val   <= s_tdata[57:26];
            hit_found <= 1'b0;
            old_found <= 1'b0;
            oth_found <= 1'b0;
            cnt       <= '0;
            report    <= 1'b1;
            if (s_tuser == MODE_CLEAR) begin
              state <= S_CLR;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_vld) begin
            if (ent_match && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= rd_idx;
            end
            // strict compare keeps the lowest index among equal ages
            if (rdata.frame < old_val) begin
              old_found <= 1'b1;
              old_idx   <= rd_idx;
              old_val   <= rdata.frame;
            end
            if (ent_other && !oth_found) begin
              oth_found <= 1'b1;
              oth_idx   <= rd_idx;
            end
          end else if (cnt == CNT_END) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          res_index  <= pick_ext[IDX_OUT_W-1:0];
          res_status <= pick_status;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, res_status, res_index};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
